[rtl/core/integer_divider_signed_unsigned_core_defines.svh]
// Assertion macros shared by the divider core.
`ifndef INTEGER_DIVIDER_SIGNED_UNSIGNED_CORE_DEFINES_SVH
`define INTEGER_DIVIDER_SIGNED_UNSIGNED_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define IDSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define IDSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/idss_pkg.sv]
// Package with the types and constants of the divider core.
package idss_pkg;

  localparam int IDSS_WORD_BITS = 32;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } idss_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic take;
  } idss_cell_ctl_t;

endpackage

[rtl/core/idss_if.sv]
// Request and response stream interfaces of the divider core.
interface idss_in_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [WORD_BITS-1:0] dividend;
  logic [WORD_BITS-1:0] divisor;

  modport source (output valid, output op, output dividend, output divisor, input ready);
  modport sink   (input valid, input op, input dividend, input divisor, output ready);
endinterface

interface idss_out_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] quotient;
  logic                 divide_by_zero;

  modport source (output valid, output quotient, output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input divide_by_zero, output ready);
endinterface

[rtl/core/integer_divider_signed_unsigned_core.sv]
// Top level of the signed and unsigned integer divider core.
// The req channel carries op, dividend and divisor; a beat is taken when
// valid and ready are both high. The rsp channel returns quotient and
// divide_by_zero, one beat per request beat, in order.
// Op selects unsigned division or signed division truncating toward zero.
// A zero divisor returns quotient zero with divide_by_zero set.
// The quotient comes from a row of WORD_BITS bit cells that shift the
// partial remainder and subtract the divisor through a ripple borrow
// chain, one quotient bit per cycle.
// A request passes through the cell row and then the sign fix-up into
// the output register before rsp valid rises. One request is in the
// cell row at a time, so a new request is taken only after the last
// one has left the fix-up state and the core is back in idle.
// Ready on req is high while the cell row is idle, even when a result
// still waits in the output register.
// When rsp stalls, the finished quotient waits in the fix-up state until
// the output register is free. Reset returns to idle and drops rsp valid.
`include "integer_divider_signed_unsigned_core_defines.svh"

module integer_divider_signed_unsigned_core
  import idss_pkg::*;
#(
  parameter int WORD_BITS = IDSS_WORD_BITS
) (
  input  logic       clk,
  input  logic       rst,
  idss_in_if.sink    req,
  idss_out_if.source rsp
);

  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  idss_state_t          state;
  idss_state_t          state_next;
  logic [CNT_BITS-1:0]  count;
  logic                 neg;
  logic                 zero_div;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_quotient;
  logic                 out_zero;
  logic                 out_load;

  logic                 accept;
  idss_cell_ctl_t       ctl;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS:0]   borrow;
  logic [WORD_BITS-1:0] a_mag;
  logic [WORD_BITS-1:0] b_mag;
  logic                 a_neg;
  logic                 b_neg;

  assign accept = req.valid & req.ready;
  assign a_neg  = (req.op == OP_SIGNED) & req.dividend[WORD_BITS-1];
  assign b_neg  = (req.op == OP_SIGNED) & req.divisor[WORD_BITS-1];
  assign a_mag  = a_neg ? (~req.dividend + 1'b1) : req.dividend;
  assign b_mag  = b_neg ? (~req.divisor + 1'b1) : req.divisor;

  assign borrow[0] = 1'b0;

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    logic rem_in;
    logic quo_in;
    if (i == 0) begin : g_low
      assign rem_in = quo[WORD_BITS-1];
      assign quo_in = ctl.take;
    end else begin : g_up
      assign rem_in = rem[i-1];
      assign quo_in = quo[i-1];
    end
    idss_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_quo   (a_mag[i]),
      .load_div   (b_mag[i]),
      .rem_in     (rem_in),
      .quo_in     (quo_in),
      .borrow_in  (borrow[i]),
      .rem        (rem[i]),
      .quo        (quo[i]),
      .borrow_out (borrow[i+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_RUN;
      end
      S_RUN: begin
        if (count == '0) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    ctl.load  = accept;
    ctl.step  = (state == S_RUN);
    ctl.take  = rem[WORD_BITS-1] | ~borrow[WORD_BITS];
    out_load  = (state == S_DONE) && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= CNT_LAST;
      end else if (state == S_RUN) begin
        count <= count - 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg      <= a_neg ^ b_neg;
      zero_div <= (req.divisor == '0);
    end
    if (out_load) begin
      out_zero <= zero_div;
      if (zero_div) begin
        out_quotient <= '0;
      end else begin
        out_quotient <= neg ? (~quo + 1'b1) : quo;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.quotient       = out_quotient;
  assign rsp.divide_by_zero = out_zero;

  `IDSS_ASSERT_NEXT(a_accept_runs, clk, rst, accept, state == S_RUN,
                    "accepted request did not start the cell row")
  `IDSS_ASSERT_NEXT(a_run_holds, clk, rst, (state == S_RUN) && (count != '0),
                    (state == S_RUN) && !req.ready, "cell row left the run early")
  `IDSS_ASSERT_NEXT(a_done_loads, clk, rst, out_load, rsp.valid && (state == S_IDLE),
                    "finished quotient did not reach the output register")
  `IDSS_ASSERT_NOW(a_zero_quotient, clk, rst, rsp.valid && rsp.divide_by_zero,
                   rsp.quotient == '0, "zero divisor gave a nonzero quotient")

endmodule

[rtl/core/idss_cell.sv]
// One bit slice of the restoring divider: remainder, quotient and divisor bits.
module idss_cell
  import idss_pkg::*;
(
  input  logic           clk,
  input  idss_cell_ctl_t ctl,
  input  logic           load_quo,
  input  logic           load_div,
  input  logic           rem_in,
  input  logic           quo_in,
  input  logic           borrow_in,
  output logic           rem,
  output logic           quo,
  output logic           borrow_out
);

  logic div;
  logic diff;

  assign diff       = rem_in ^ div ^ borrow_in;
  assign borrow_out = (~rem_in & div) | (~rem_in & borrow_in) | (div & borrow_in);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= 1'b0;
      quo <= load_quo;
      div <= load_div;
    end else if (ctl.step) begin
      rem <= ctl.take ? diff : rem_in;
      quo <= quo_in;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench of the signed and unsigned integer divider core.
module testbench
  import idss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = IDSS_WORD_BITS;
  localparam int RANDOM_BEATS = 1100;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 600000;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         divide_by_zero;
  } quot_t;

  typedef struct packed {
    logic         op;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         typed;
    quot_t        want;
  } div_row_t;

  localparam int NUM_ROWS = 23;
  localparam quot_t NONE = '0;

  localparam div_row_t DIV_ROWS [0:NUM_ROWS-1] = '{
    '{OP_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    '{OP_SIGNED,   32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    '{OP_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    '{OP_SIGNED,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1}},
    '{OP_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1'b0}},
    '{OP_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
    '{OP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 1'b0}},
    '{OP_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0}},
    '{OP_UNSIGNED, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0}},
    '{OP_SIGNED,   32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0}},
    '{OP_SIGNED,   32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 1'b0}},
    '{OP_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
    '{OP_SIGNED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 1'b0}},
    '{OP_SIGNED,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0001, 1'b0}},
    '{OP_SIGNED,   32'h8000_0000, 32'h0000_0002, 1'b0, NONE},
    '{OP_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE, 1'b0, NONE},
    '{OP_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002, 1'b0, NONE},
    '{OP_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, NONE},
    '{OP_UNSIGNED, 32'h0000_0007, 32'h0000_0002, 1'b0, NONE},
    '{OP_UNSIGNED, 32'h8000_0000, 32'h8000_0000, 1'b0, NONE},
    '{OP_UNSIGNED, 32'h1234_5678, 32'h0000_0100, 1'b0, NONE},
    '{OP_UNSIGNED, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NONE},
    '{OP_SIGNED,   32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NONE}
  };

  logic clk;
  logic rst;

  idss_in_if  #(.WORD_BITS(W)) req_if ();
  idss_out_if #(.WORD_BITS(W)) rsp_if ();

  integer_divider_signed_unsigned_core #(.WORD_BITS(W)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  quot_t quot_expected [$];
  int    errors;
  int    beats_sent;
  int    beats_signed;
  int    beats_zero_div;
  int    results_seen;
  int    cycle_count;
  int    burst_left;
  bit    gaps_on;
  bit    hold_off;

  function automatic quot_t divide_word(logic op, logic [W-1:0] a, logic [W-1:0] b);
    quot_t        r;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] q;
    r = '0;
    if (b == '0) begin
      r.divide_by_zero = 1'b1;
      return r;
    end
    if (op == OP_SIGNED) begin
      ma = a[W-1] ? (~a + 1'b1) : a;
      mb = b[W-1] ? (~b + 1'b1) : b;
      q  = ma / mb;
      if (a[W-1] != b[W-1]) begin
        q = ~q + 1'b1;
      end
    end else begin
      q = a / b;
    end
    r.quotient = q;
    return r;
  endfunction

  function automatic logic [W-1:0] rand_word();
    logic [W-1:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: w = '0;
          1: w = 1;
          2: w = MOST_POS;
          3: w = MOST_NEG;
          default: w = ALL_ONES;
        endcase
      end
      1: w = $urandom_range(0, 15);
      2: w = ~W'($urandom_range(0, 14));
      3: w = $urandom >> $urandom_range(1, W - 1);
      4: w = ~($urandom >> $urandom_range(1, W - 1));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("MISMATCH %s at result %0d: got %h, want %h", what, results_seen, got, want);
    errors++;
  endtask

  task automatic send_beat(logic op, logic [W-1:0] a, logic [W-1:0] b, logic typed,
                           quot_t typed_want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 40) : 0;
      if (gap > 0) begin
        req_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_if.op       = op;
    req_if.dividend = a;
    req_if.divisor  = b;
    req_if.valid    = 1'b1;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    quot_expected.push_back(typed ? typed_want : divide_word(op, a, b));
    beats_sent++;
    if (op == OP_SIGNED) beats_signed++;
    if (b == '0) beats_zero_div++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               quot_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    quot_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (quot_expected.size() == 0) begin
        report_mismatch("unexpected beat", rsp_if.quotient, '0);
      end else begin
        want = quot_expected.pop_front();
        if (rsp_if.quotient !== want.quotient)
          report_mismatch("quotient", rsp_if.quotient, want.quotient);
        if (rsp_if.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", W'(rsp_if.divide_by_zero),
                          W'(want.divide_by_zero));
      end
      results_seen++;
    end
  end

  initial begin : receiver
    int seg_left;
    int mode;
    int stall_left;
    int hold_left;
    seg_left     = 0;
    mode         = 0;
    stall_left   = 0;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else if (hold_off) begin
        hold_off     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        rsp_if.ready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          0: rsp_if.ready = 1'b1;
          1: rsp_if.ready = 1'($urandom_range(0, 1));
          2: rsp_if.ready = ($urandom_range(0, 3) == 0);
          default: begin
            if (stall_left > 0) begin
              rsp_if.ready = 1'b0;
              stall_left--;
            end else if ($urandom_range(0, 15) == 0) begin
              rsp_if.ready = 1'b0;
              stall_left   = $urandom_range(5, 60);
            end else begin
              rsp_if.ready = 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin : sender
    logic         op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.op       = OP_UNSIGNED;
    req_if.dividend = '0;
    req_if.divisor  = '0;
    errors          = 0;
    beats_sent      = 0;
    beats_signed    = 0;
    beats_zero_div  = 0;
    results_seen    = 0;
    cycle_count     = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    hold_off        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_beat(DIV_ROWS[i].op, DIV_ROWS[i].dividend, DIV_ROWS[i].divisor,
                DIV_ROWS[i].typed, DIV_ROWS[i].want);
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 150 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i == 200) hold_off = 1'b1;
      if (i == 500 || i == 800) begin
        req_if.valid = 1'b0;
        burst_left   = 0;
        while (quot_expected.size() != 0) @(negedge clk);
      end
      op = 1'($urandom_range(0, 1));
      a  = rand_word();
      b  = ($urandom_range(0, 19) == 0) ? '0 : rand_word();
      send_beat(op, a, b, 1'b0, NONE);
    end
    req_if.valid = 1'b0;

    while (quot_expected.size() != 0) @(posedge clk);
    repeat (4 * (W + 2)) @(posedge clk);

    $display("Covered %0d division beats: %0d signed, %0d unsigned, %0d with a zero divisor.",
             beats_sent, beats_signed, beats_sent - beats_signed, beats_zero_div);
    $display("Checked %0d results across random stalls and one %0d-cycle hold-off; %0d errors.",
             results_seen, HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
